@@ design/tkns_pkg.sv @@
// shared constants and controller/datapath interface types for the top-k selector
package tkns_pkg;

  localparam int MAX_K_DEFAULT = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [4:0] K_RESET = 5'd16;

  typedef struct packed {
    logic load;
    logic clr;
    logic rd_start;
    logic cmp;
    logic ins;
    logic rot;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic emit_due;
    logic rd_end;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/tkns_ctrl.sv @@
// controller state machine sequencing insert, read-out and clear
module tkns_ctrl
  import tkns_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  input  dp_status_t status,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_INS  = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE) && !rst;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (in_cmd)
            CMD_INSERT: begin
              cmd.load   = 1'b1;
              state_next = ST_CMP;
            end
            CMD_READ: begin
              if (!status.count_zero) begin
                cmd.rd_start = 1'b1;
                state_next   = ST_READ;
              end
            end
            CMD_CLEAR: begin
              cmd.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = ST_INS;
      end
      ST_INS: begin
        cmd.ins    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        if (!status.emit_due || status.out_free) begin
          cmd.rot  = 1'b1;
          cmd.emit = status.emit_due;
          if (status.rd_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/tkns_datapath.sv @@
// sorted register chain, compare flags, rotation counter and output register
module tkns_datapath
  import tkns_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic [31:0] in_id,
  input  logic [31:0] in_dist,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_id,
  output logic [31:0] out_dist,
  output logic        out_last
);

  localparam int CNT_W = $clog2(MAX_K + 1);
  localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  logic [63:0]      entry      [MAX_K];
  logic [63:0]      entry_next [MAX_K];
  logic [63:0]      key;
  logic [CNT_W-1:0] count;
  logic [4:0]       k_reg;
  logic [MAX_K-1:0] gt_flag, gt_key_r;
  logic [MAX_K-1:0] lt_dist, lt_dist_r;
  logic             full, full_r;
  logic [CNT_W-1:0] lim;
  logic [CMP_W-1:0] eff_k;
  logic [IDX_W-1:0] idx;
  logic             do_ins;

  // clamp k into 1..MAX_K
  always_comb begin
    if (k_reg == '0) begin
      eff_k = CMP_W'(1);
    end else if (CMP_W'(k_reg) > CMP_W'(MAX_K)) begin
      eff_k = CMP_W'(MAX_K);
    end else begin
      eff_k = CMP_W'(k_reg);
    end
  end

  assign full   = CMP_W'(count) >= eff_k;
  assign lim    = full ? (count - CNT_W'(1)) : count;
  assign do_ins = !full_r || (|lt_dist_r);

  genvar i;
  generate
    for (i = 0; i < MAX_K; i++) begin : g_cell
      // slots at or above the limit act as empty
      assign gt_flag[i] = (CNT_W'(i) >= lim) || (entry[i] > key);
      assign lt_dist[i] = (CNT_W'(i) < count) && (key[63:32] < entry[i][63:32]);

      if (i == 0) begin : g_head
        always_comb begin
          entry_next[i] = entry[i];
          if (cmd.ins && do_ins) begin
            if (gt_key_r[i]) begin
              entry_next[i] = key;
            end
          end else if (cmd.rot) begin
            entry_next[i] = entry[(i + 1) % MAX_K];
          end
        end
      end else begin : g_body
        always_comb begin
          entry_next[i] = entry[i];
          if (cmd.ins && do_ins) begin
            if (gt_key_r[i]) begin
              entry_next[i] = gt_key_r[i-1] ? entry[i-1] : key;
            end
          end else if (cmd.rot) begin
            entry_next[i] = entry[(i + 1) % MAX_K];
          end
        end
      end

      always_ff @(posedge clk) begin
        entry[i] <= entry_next[i];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= {in_dist, in_id};
    end
    if (cmd.cmp) begin
      gt_key_r  <= gt_flag;
      lt_dist_r <= lt_dist;
      full_r    <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      k_reg <= K_RESET;
      idx   <= '0;
    end else begin
      if (cfg_we) begin
        k_reg <= cfg_wdata;
      end
      if (cmd.clr) begin
        count <= '0;
      end else if (cmd.ins && do_ins && !full_r) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.rd_start) begin
        idx <= '0;
      end else if (cmd.rot) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  assign status.count_zero = (count == '0);
  assign status.emit_due   = CNT_W'(idx) < count;
  assign status.rd_end     = (idx == IDX_W'(MAX_K - 1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_id   <= entry[0][31:0];
      out_dist <= entry[0][63:32];
      out_last <= (CNT_W'(idx) + CNT_W'(1)) == count;
    end
  end

endmodule

@@ design/top_k_nearest_selector_unit.sv @@
// top level of the top-k nearest candidate selector
// Keeps the k nearest candidates (k from cfg_wdata, clamped to 1..MAX_K) in a sorted
// register chain. An insert runs through the transaction, a step that registers a compare
// of the candidate against every slot of the chain, and a step that shifts it into place.
// Clear and unused commands complete on acceptance. During a read the chain rotates
// through all MAX_K slots, one a cycle unless a held-low m_tready stalls it, emitting
// the kept entries in ascending order and returning to its original order.
// A read of an empty store emits nothing. The output register lets a new transaction be
// accepted while a result still waits. No clearing pass is needed after reset.
module top_k_nearest_selector_unit
  import tkns_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,   // k_in_use
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,     // item_id [31:0], item_distance [63:32]
  input  logic [1:0]  s_tuser,     // command [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,     // entry_id [31:0], entry_distance [63:32]
  output logic        m_tlast
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tkns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  tkns_datapath #(
    .MAX_K (MAX_K)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_id     (s_tdata[31:0]),
    .in_dist   (s_tdata[63:32]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_id    (m_tdata[31:0]),
    .out_dist  (m_tdata[63:32]),
    .out_last  (m_tlast)
  );

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded while output register still full");

  a_insert_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_INSERT) |=> !s_tready)
    else $error("new transaction accepted during insert");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.emit))
    else $error("output valid without a read-out step");

endmodule
